// File: hw/rtl/arrive_steering_velocity_assert.svh
// Assertion macros used by the steering datapath
`ifndef ARRIVE_STEERING_VELOCITY_ASSERT_SVH
`define ARRIVE_STEERING_VELOCITY_ASSERT_SVH
`ifndef SYNTHESIS
`define ASV_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ASV_IMPLY(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) else $error(msg);
`define ASV_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) else $error(msg);
`else
`define ASV_CHECK(lbl, expr, msg)
`define ASV_IMPLY(lbl, cond, expr, msg)
`define ASV_NEXT(lbl, cond, expr, msg)
`endif
`endif

// File: hw/rtl/asv_pkg.sv
// Types and constants of the arrive steering datapath
`timescale 1ns / 1ps
package asv_pkg;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 31;
  localparam int unsigned IN_W       = 9 * DATA_W;
  localparam int unsigned OUT_W      = 3 * DATA_W;
  localparam int unsigned SQ_W       = 2 * DATA_W;
  localparam int unsigned RAD_W      = SQ_W + 2;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned Q_W        = CFG_W;
  localparam int unsigned RAMP_NUM_W = 2 * CFG_W;
  localparam int unsigned SCL_NUM_W  = DATA_W + CFG_W;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] REG_STOP_RADIUS = 2'd1;
  localparam logic [1:0] REG_SLOW_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] STOP_RADIUS_RST = 31'd65536;
  localparam logic [CFG_W-1:0] SLOW_RADIUS_RST = 31'd262144;

  typedef enum logic [1:0] {
    MODE_SCALE,
    MODE_PASS,
    MODE_ZERO
  } asv_mode_e;

  typedef struct packed {
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] stop_radius;
    logic [CFG_W-1:0] slow_radius;
  } asv_cfg_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] cmag;
    logic [2:0]             cneg;
    logic                   use_max;
    asv_mode_e              mode;
  } asv_item_t;

  localparam int unsigned ITEM_W = $bits(asv_item_t);
endpackage

// File: hw/rtl/arrive_steering_velocity.sv
// Top level of the kinematic arrive steering engine
//
//  channel   role    payload
//  s_axis    in      tdata: self_x..z, goal_x..z, goal_vel_x..z, 32 bits each
//  m_axis    out     tdata: vel_x, vel_y, vel_z, 32 bits each
//  apb       config  max_speed @0x0, stop_radius @0x4, slow_radius @0x8
//
// One transfer in and one out per cycle while the output skid is empty; the pipe holds
// the 33-stage square root and the two 31-stage dividers.
// All pipeline stages advance on one enable; a two-entry output (register plus
// skid) lets one more result leave the pipe while the consumer stalls.
// Reset clears valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "arrive_steering_velocity_assert.svh"
module arrive_steering_velocity import asv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // self_x, self_y, self_z, goal_x, goal_y, goal_z, goal_vel_x, goal_vel_y, goal_vel_z
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // vel_x, vel_y, vel_z
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  asv_cfg_t                   cfg_q;
  logic                       en;
  logic                       fr_v, sq_v, ramp_v, scl_v;
  logic [RAD_W-1:0]           fr_rad;
  asv_item_t                  fr_item, sq_item, ramp_item, scl_item;
  logic [ROOT_W-1:0]          sq_root, ramp_len;
  logic [ITEM_W-1:0]          sq_side, scl_side;
  logic [ITEM_W+ROOT_W-1:0]   ramp_side;
  logic [0:0][Q_W-1:0]        ramp_q;
  logic [2:0][Q_W-1:0]        scl_q;

  logic                       r1_v_q, r2_v_q, m_v_q;
  logic [CFG_W-1:0]           dstop_q, span1_q, span2_q;
  logic [ROOT_W-1:0]          len1_q, len2_q, len3_q;
  asv_item_t                  item1_q, item2_q, item3_q;
  logic [0:0][RAMP_NUM_W-1:0] rnum_q;
  logic [CFG_W-1:0]           speed;
  logic [2:0][SCL_NUM_W-1:0]  snum_q;

  logic [2:0][DATA_W-1:0]     fin_data;
  logic                       out_v_q, skid_v_q;
  logic [OUT_W-1:0]           out_data_q, skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_speed: MAX_SPEED_RST, stop_radius: STOP_RADIUS_RST,
                 slow_radius: SLOW_RADIUS_RST};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[CFG_W-1:0];
        REG_STOP_RADIUS: cfg_q.stop_radius <= pwdata[CFG_W-1:0];
        REG_SLOW_RADIUS: cfg_q.slow_radius <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_SPEED:   prdata = PDATA_W'(cfg_q.max_speed);
      REG_STOP_RADIUS: prdata = PDATA_W'(cfg_q.stop_radius);
      REG_SLOW_RADIUS: prdata = PDATA_W'(cfg_q.slow_radius);
      default:         prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  asv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .cfg_i   (cfg_q),
    .valid_o (fr_v),
    .rad_o   (fr_rad),
    .item_o  (fr_item)
  );

  asv_isqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W (ITEM_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_rad),
    .side_i  (fr_item),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );
  assign sq_item = asv_item_t'(sq_side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else if (en) begin
      r1_v_q <= sq_v;
      r2_v_q <= r1_v_q;
      m_v_q  <= ramp_v;
    end
  end

  assign speed = ramp_item.use_max ? cfg_q.max_speed : ramp_q[0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dstop_q   <= sq_root[CFG_W-1:0] - cfg_q.stop_radius;
      span1_q   <= cfg_q.slow_radius - cfg_q.stop_radius;
      len1_q    <= sq_root;
      item1_q   <= sq_item;
      rnum_q[0] <= RAMP_NUM_W'(cfg_q.max_speed) * RAMP_NUM_W'(dstop_q);
      span2_q   <= span1_q;
      len2_q    <= len1_q;
      item2_q   <= item1_q;
      for (int i = 0; i < 3; i++) begin
        snum_q[i] <= SCL_NUM_W'(ramp_item.cmag[i]) * SCL_NUM_W'(speed);
      end
      len3_q    <= ramp_len;
      item3_q   <= ramp_item;
    end
  end

  asv_div #(
    .LANES  (1),
    .NUM_W  (RAMP_NUM_W),
    .DEN_W  (CFG_W),
    .Q_W    (Q_W),
    .SIDE_W (ITEM_W + ROOT_W)
  ) u_ramp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r2_v_q),
    .num_i   (rnum_q),
    .den_i   (span2_q),
    .side_i  ({len2_q, item2_q}),
    .valid_o (ramp_v),
    .quo_o   (ramp_q),
    .side_o  (ramp_side)
  );
  assign {ramp_len, ramp_item} = ramp_side;

  asv_div #(
    .LANES  (3),
    .NUM_W  (SCL_NUM_W),
    .DEN_W  (ROOT_W),
    .Q_W    (Q_W),
    .SIDE_W (ITEM_W)
  ) u_scale_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_v_q),
    .num_i   (snum_q),
    .den_i   (len3_q),
    .side_i  (item3_q),
    .valid_o (scl_v),
    .quo_o   (scl_q),
    .side_o  (scl_side)
  );
  assign scl_item = asv_item_t'(scl_side);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (scl_item.mode)
        MODE_SCALE: fin_data[i] = scl_item.cneg[i] ? (DATA_W'(0) - {1'b0, scl_q[i]})
                                                   : {1'b0, scl_q[i]};
        MODE_PASS:  fin_data[i] = scl_item.cneg[i] ? (DATA_W'(0) - scl_item.cmag[i])
                                                   : scl_item.cmag[i];
        MODE_ZERO:  fin_data[i] = '0;
        default:    fin_data[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end else if (scl_v) begin
      if (!out_v_q || m_axis_tready) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
      end
    end else if (scl_v) begin
      if (!out_v_q || m_axis_tready) begin
        out_data_q <= fin_data;
      end else begin
        skid_data_q <= fin_data;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  `ASV_IMPLY(a_skid_needs_out, skid_v_q, out_v_q, "skid entry without output entry")
  `ASV_NEXT(a_skid_holds, skid_v_q && !m_axis_tready, skid_v_q, "skid entry lost")
  `ASV_NEXT(a_skid_fills, scl_v && en && out_v_q && !m_axis_tready, skid_v_q,
            "result dropped while output stalled")
  `ASV_IMPLY(a_ramp_bound, ramp_v && !ramp_item.use_max, ramp_q[0] <= cfg_q.max_speed,
             "ramp speed above maximum")
endmodule

// File: hw/rtl/asv_front.sv
// Front stages: differences, squares, sums and path selection
`timescale 1ns / 1ps
module asv_front import asv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [IN_W-1:0]  data_i,
  input  asv_cfg_t         cfg_i,
  output logic             valid_o,
  output logic [RAD_W-1:0] rad_o,
  output asv_item_t        item_o
);
  logic [2:0][DATA_W-1:0] self_c, goal_c, gvel_c, dmag_c, vmag_c;
  logic [2:0][DATA_W:0]   diff_c;
  logic [2:0]             dneg_c, vneg_c;

  logic [3:0]             vld_q;
  logic [2:0][DATA_W-1:0] dmag1_q, vmag1_q, dmag2_q, vmag2_q, dmag3_q, vmag3_q;
  logic [2:0]             dneg1_q, vneg1_q, dneg2_q, vneg2_q, dneg3_q, vneg3_q;
  logic [2:0][SQ_W-1:0]   dsq2_q, vsq2_q;
  logic [RAD_W-1:0]       dsum3_q, rad_q;
  logic [SQ_W-1:0]        vsum3_q;
  logic [RAMP_NUM_W-1:0]  max2_q, stop2_q, slow2_q;
  asv_item_t              item_d, item_q;
  logic [RAD_W-1:0]       rad_d;
  logic                   near, full, exceed, zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      self_c[i] = data_i[i*DATA_W +: DATA_W];
      goal_c[i] = data_i[(i+3)*DATA_W +: DATA_W];
      gvel_c[i] = data_i[(i+6)*DATA_W +: DATA_W];
      diff_c[i] = {goal_c[i][DATA_W-1], goal_c[i]} - {self_c[i][DATA_W-1], self_c[i]};
      dneg_c[i] = diff_c[i][DATA_W];
      dmag_c[i] = dneg_c[i] ? (~diff_c[i][DATA_W-1:0] + 1'b1) : diff_c[i][DATA_W-1:0];
      vneg_c[i] = gvel_c[i][DATA_W-1];
      vmag_c[i] = vneg_c[i] ? (~gvel_c[i] + 1'b1) : gvel_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    max2_q  <= RAMP_NUM_W'(cfg_i.max_speed) * RAMP_NUM_W'(cfg_i.max_speed);
    stop2_q <= RAMP_NUM_W'(cfg_i.stop_radius) * RAMP_NUM_W'(cfg_i.stop_radius);
    slow2_q <= RAMP_NUM_W'(cfg_i.slow_radius) * RAMP_NUM_W'(cfg_i.slow_radius);
  end

  always_comb begin
    near   = dsum3_q < RAD_W'(stop2_q);
    full   = dsum3_q >= RAD_W'(slow2_q);
    exceed = vsum3_q > SQ_W'(max2_q);
    zero   = dsum3_q == '0;
    rad_d  = near ? RAD_W'(vsum3_q) : dsum3_q;
    item_d.cmag    = near ? vmag3_q : dmag3_q;
    item_d.cneg    = near ? vneg3_q : dneg3_q;
    item_d.use_max = near | full;
    if (near) begin
      item_d.mode = exceed ? MODE_SCALE : MODE_PASS;
    end else begin
      item_d.mode = zero ? MODE_ZERO : MODE_SCALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag1_q <= dmag_c;
      dneg1_q <= dneg_c;
      vmag1_q <= vmag_c;
      vneg1_q <= vneg_c;
      for (int i = 0; i < 3; i++) begin
        dsq2_q[i] <= SQ_W'(dmag1_q[i]) * SQ_W'(dmag1_q[i]);
        vsq2_q[i] <= SQ_W'(vmag1_q[i]) * SQ_W'(vmag1_q[i]);
      end
      dmag2_q <= dmag1_q;
      dneg2_q <= dneg1_q;
      vmag2_q <= vmag1_q;
      vneg2_q <= vneg1_q;
      dsum3_q <= RAD_W'(dsq2_q[0]) + RAD_W'(dsq2_q[1]) + RAD_W'(dsq2_q[2]);
      vsum3_q <= vsq2_q[0] + vsq2_q[1] + vsq2_q[2];
      dmag3_q <= dmag2_q;
      dneg3_q <= dneg2_q;
      vmag3_q <= vmag2_q;
      vneg3_q <= vneg2_q;
      rad_q   <= rad_d;
      item_q  <= item_d;
    end
  end

  assign valid_o = vld_q[3];
  assign rad_o   = rad_q;
  assign item_o  = item_q;
endmodule

// File: hw/rtl/asv_isqrt.sv
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module asv_isqrt #(
  parameter int unsigned RAD_W  = 66,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]    side_o
);
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned WK_W   = ROOT_W + 3;

  logic [ROOT_W-1:0] vld_q;
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [WK_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [WK_W-1:0]   rem_in, acc, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign acc   = {rem_in[WK_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? acc - trial : acc;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
endmodule

// File: hw/rtl/asv_div.sv
// Pipelined restoring divider, lanes share one divisor
`timescale 1ns / 1ps
module asv_div #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned NUM_W  = 62,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]                den_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][Q_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]               side_o
);
  logic [Q_W-1:0]                    vld_q;
  logic [DEN_W-1:0]                  den_q  [Q_W];
  logic [LANES-1:0][DEN_W:0]         rem_q  [Q_W];
  logic [LANES-1:0][Q_W-1:0]         lo_q   [Q_W];
  logic [LANES-1:0][Q_W-1:0]         quo_q  [Q_W];
  logic [SIDE_W-1:0]                 side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic                      vld_in;
    logic [DEN_W-1:0]          den_in;
    logic [LANES-1:0][DEN_W:0] rem_in, acc, rem_d;
    logic [LANES-1:0][Q_W-1:0] lo_in, quo_in, quo_d;
    logic [SIDE_W-1:0]         side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_ln
        assign rem_in[l] = (DEN_W+1)'(num_i[l][NUM_W-1:Q_W]);
        assign lo_in[l]  = num_i[l][Q_W-1:0];
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] = {rem_in[l][DEN_W-1:0], lo_in[l][Q_W-1]};
        if (acc[l] >= {1'b0, den_in}) begin
          rem_d[l] = acc[l] - {1'b0, den_in};
          quo_d[l] = {quo_in[l][Q_W-2:0], 1'b1};
        end else begin
          rem_d[l] = acc[l];
          quo_d[l] = {quo_in[l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          lo_q[k][l] <= lo_in[l] << 1;
        end
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];
endmodule

// File: dv/tb_arrive_steering_velocity.sv
// Testbench for the arrive steering block: random and directed agents checked against a predictor
`timescale 1ns / 1ps
module tb_arrive_steering_velocity;
  import asv_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // self_x, self_y, self_z, goal_x, goal_y, goal_z, goal_vel_x, goal_vel_y, goal_vel_z
  logic [IN_W-1:0]    s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // vel_x, vel_y, vel_z
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [CFG_W-1:0]   max_speed_q;
  logic [CFG_W-1:0]   stop_radius_q;
  logic [CFG_W-1:0]   slow_radius_q;

  logic [IN_W-1:0]    agent_q[$];
  logic [OUT_W-1:0]   vel_expected_q[$];
  int                 src_idle;
  int                 snk_idle;
  int                 stall_cycles;
  int                 errors;
  bit                 quiet;

  arrive_steering_velocity u_top (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [34:0] isqrt(logic [67:0] n);
    logic [34:0] r;
    logic [34:0] c;
    logic [69:0] sq;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      sq = 70'(c) * 70'(c);
      if (sq <= 70'(n)) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] arrive_velocity(logic [IN_W-1:0] din);
    logic signed [32:0] d[3];
    logic [32:0]        dmag[3];
    logic [31:0]        v[3];
    logic [31:0]        vmag[3];
    logic [67:0]        dsq;
    logic [67:0]        vsq;
    logic [67:0]        msq;
    logic [34:0]        dlen;
    logic [34:0]        vlen;
    logic [63:0]        spd;
    logic [63:0]        m;
    logic [OUT_W-1:0]   r;
    dsq = '0;
    vsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({din[96+32*i+31], din[96+32*i+:32]}) -
             $signed({din[32*i+31], din[32*i+:32]});
      dmag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      v[i] = din[192+32*i+:32];
      vmag[i] = v[i][31] ? -v[i] : v[i];
      dsq = dsq + 68'(dmag[i]) * 68'(dmag[i]);
      vsq = vsq + 68'(vmag[i]) * 68'(vmag[i]);
    end
    dlen = isqrt(dsq);
    msq = 68'(max_speed_q) * 68'(max_speed_q);
    if (dlen < 35'(stop_radius_q)) begin
      if (vsq > msq) begin
        vlen = isqrt(vsq);
        for (int i = 0; i < 3; i++) begin
          m = 64'(vmag[i]) * 64'(max_speed_q) / 64'(vlen);
          r[32*i+:32] = v[i][31] ? -m[31:0] : m[31:0];
        end
      end else begin
        for (int i = 0; i < 3; i++) r[32*i+:32] = v[i];
      end
    end else begin
      if (dlen >= 35'(slow_radius_q)) spd = 64'(max_speed_q);
      else spd = 64'(max_speed_q) * 64'(dlen - 35'(stop_radius_q)) /
                 64'(slow_radius_q - stop_radius_q);
      for (int i = 0; i < 3; i++) begin
        if (dlen == 0) begin
          r[32*i+:32] = '0;
        end else begin
          m = 64'(dmag[i]) * spd / 64'(dlen);
          r[32*i+:32] = d[i][32] ? -m[31:0] : m[31:0];
        end
      end
    end
    return r;
  endfunction

  function automatic void push_agent(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                     logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                                     logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    agent_q.push_back({vz, vy, vx, gz, gy, gx, sz, sy, sx});
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic void push_random_agent();
    logic [31:0] s[3];
    logic [31:0] dl[3];
    logic [31:0] v[3];
    logic [31:0] rad;
    int          kind;
    int          ax;
    kind = $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: rad = stop_radius_q;
      1: rad = slow_radius_q;
      2: rad = max_speed_q;
      default: rad = $urandom_range(0, slow_radius_q);
    endcase
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      s[i] = (kind == 0) ? $urandom() : jitter(32'h0010_0000);
      case (kind)
        0, 1: dl[i] = $urandom();
        2: dl[i] = '0;
        3, 4: dl[i] = (i == ax) ? rad + jitter(2) : '0;
        default: dl[i] = jitter(rad >> 1);
      endcase
      if (kind == 4 && i == ax && $urandom_range(0, 1)) dl[i] = -dl[i];
      v[i] = $urandom_range(0, 1) ? $urandom() : jitter(max_speed_q);
    end
    push_agent(s[0], s[1], s[2], s[0] + dl[0], s[1] + dl[1], s[2] + dl[2],
               v[0], v[1], v[2]);
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MAX_SPEED:   max_speed_q   = value[CFG_W-1:0];
      REG_STOP_RADIUS: stop_radius_q = value[CFG_W-1:0];
      default:         slow_radius_q = value[CFG_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (agent_q.size() != 0 || s_axis_tvalid || vel_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [31:0] ms, logic [31:0] stop, logic [31:0] slow, int count);
    apb_write(REG_MAX_SPEED, ms);
    apb_write(REG_STOP_RADIUS, stop);
    apb_write(REG_SLOW_RADIUS, slow);
    push_agent(0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    for (int i = 0; i < count; i++) push_random_agent();
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_idle      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_idle > 0) begin
        src_idle      <= src_idle - 1;
        s_axis_tvalid <= 1'b0;
      end else if (agent_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        src_idle      <= $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else if (agent_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= agent_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_idle      <= 0;
    end else if (snk_idle > 0) begin
      snk_idle      <= snk_idle - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      snk_idle      <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] exp_vel;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        vel_expected_q.push_back(arrive_velocity(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (vel_expected_q.size() == 0) begin
          $display("%0t: unexpected velocity %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_vel = vel_expected_q.pop_front();
          for (int i = 0; i < 3; i++)
            if (m_axis_tdata[32*i+:32] !== exp_vel[32*i+:32]) begin
              $display("%0t: vel[%0d] expected %h actual %h", $time, i,
                       exp_vel[32*i+:32], m_axis_tdata[32*i+:32]);
              errors++;
            end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (agent_q.size() == 0 && !s_axis_tvalid && vel_expected_q.size() == 0))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("arrive_steering_velocity test failed");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    stall_cycles  = 0;
    quiet         = 1'b0;
    max_speed_q   = MAX_SPEED_RST;
    stop_radius_q = STOP_RADIUS_RST;
    slow_radius_q = SLOW_RADIUS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_agent(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_agent(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    push_agent(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push_agent(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_agent(5, 6, 7, 5, 6, 7, 32'h0000_8000, 32'hffff_8000, 0);
    push_agent(0, 0, 0, 32'h0000_ffff, 0, 0, 32'h0003_0000, 0, 0);
    push_agent(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0003_0000, 0, 0);
    push_agent(0, 0, 0, 0, 32'hffff_0000, 0, 0, 0, 0);
    push_agent(0, 0, 0, 0, 0, 32'h0002_8000, 0, 0, 0);
    push_agent(0, 0, 0, 0, 0, 32'hfffc_0001, 0, 0, 0);
    push_agent(0, 0, 0, 32'h0004_0000, 0, 0, 0, 0, 0);
    push_agent(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0);
    push_agent(32'h1234_5678, 0, 0, 32'h1234_5678, 0, 0, 32'h0001_0000, 0, 0);
    push_agent(0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0000_0001);
    drain();

    run_phase(32'hffff_ffff, 0, 0, 300);
    run_phase(0, 32'h7fff_ffff, 32'h7fff_ffff, 300);
    run_phase($urandom_range(1, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
              $urandom_range(0, 32'h0040_0000), 300);
    run_phase(32'h0002_0000, 32'h0008_0000, 32'h0003_0000, 300);
    run_phase(32'h7fff_ffff, 32'h0001_0000, 32'h7fff_ffff, 300);
    quiet = 1'b1;
    run_phase(32'h0001_8000, 32'h0000_8000, 32'h0010_0000, 300);

    repeat (120) @(posedge clk_i);
    if (errors == 0 && vel_expected_q.size() == 0)
      $display("arrive_steering_velocity test passed");
    else
      $display("arrive_steering_velocity test failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/asv_pkg.sv
hw/rtl/asv_front.sv
hw/rtl/asv_isqrt.sv
hw/rtl/asv_div.sv
hw/rtl/arrive_steering_velocity.sv
dv/tb_arrive_steering_velocity.sv
